// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(lbl, clk_sig, rst_sig, ante, cons) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("assertion failed: implication does not hold");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(lbl, clk_sig, rst_sig, ante, cons) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication does not hold");

`endif

// ----- rtl/cpwt_pkg.sv -----
// ----------------------------------------------------------------------------
// Code page write tracker package
// Sizes, codes and types shared by the tracker modules.
// ----------------------------------------------------------------------------
package cpwt_pkg;

  localparam int FAST_RAM_BYTES = 32768;
  localparam int WORK_RAM_BYTES = 262144;
  localparam int PAGE_SHIFT     = 8;

  localparam int ADDR_W         = 32;
  localparam int INSN_W         = 10;
  localparam int WSIZE_W        = 16;
  localparam int COUNT_W        = 32;
  localparam int KIND_W         = 2;
  localparam int REGION_SHIFT   = 24;
  localparam int REGION_W       = ADDR_W - REGION_SHIFT;

  localparam logic [REGION_W-1:0] REGION_FAST = REGION_W'(8'h03);
  localparam logic [REGION_W-1:0] REGION_WORK = REGION_W'(8'h02);

  localparam int MAX_RAM_BYTES  = (FAST_RAM_BYTES > WORK_RAM_BYTES) ?
                                  FAST_RAM_BYTES : WORK_RAM_BYTES;
  localparam int OFF_W          = $clog2(MAX_RAM_BYTES);
  // Offset plus byte count never overflows this width.
  localparam int END_W          = ((OFF_W > WSIZE_W) ? OFF_W : WSIZE_W) + 1;

  localparam int PAGE_BYTES     = 1 << PAGE_SHIFT;
  localparam int FAST_PAGES     = ((FAST_RAM_BYTES - 1) >> PAGE_SHIFT) + 1;
  localparam int WORK_PAGES     = ((WORK_RAM_BYTES - 1) >> PAGE_SHIFT) + 1;

  // Both bitmaps live in one memory of 32-bit rows, fast RAM rows first.
  localparam int ROW_BITS       = 32;
  localparam int BIT_W          = $clog2(ROW_BITS);
  localparam int FAST_ROWS      = (FAST_PAGES + ROW_BITS - 1) / ROW_BITS;
  localparam int WORK_ROWS      = (WORK_PAGES + ROW_BITS - 1) / ROW_BITS;
  localparam int NUM_ROWS       = FAST_ROWS + WORK_ROWS;
  localparam int ROW_W          = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;

  localparam logic [END_W-1:0] FAST_MASK  = END_W'(FAST_RAM_BYTES - 1);
  localparam logic [END_W-1:0] WORK_MASK  = END_W'(WORK_RAM_BYTES - 1);
  localparam logic [END_W-1:0] PAGE_STEP  = END_W'(PAGE_BYTES);
  localparam logic [END_W-1:0] WORK_BASE  = END_W'(FAST_ROWS);

  localparam int QUEUE_DEPTH    = 2;
  localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

  localparam int IN_TDATA_W     = 64;
  localparam int OUT_TDATA_W    = 40;

  typedef enum logic [KIND_W-1:0] {
    KIND_MARK  = 2'd0,
    KIND_CHECK = 2'd1,
    KIND_RESET = 2'd2,
    KIND_TAKE  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_MARK,
    OP_CHECK,
    OP_RESET,
    OP_TAKE
  } op_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_TEST,
    BK_DONE
  } bk_state_t;

  typedef struct packed {
    op_t                op;
    logic               fast;
    logic [END_W-1:0]   start;
    logic [WSIZE_W-1:0] bytes;
  } cmd_t;

endpackage

// ----- rtl/cpwt_front.sv -----
// ----------------------------------------------------------------------------
// Tracker front end
// Accepts input words, picks the region and turns each word into a command.
// ----------------------------------------------------------------------------
module cpwt_front (
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [cpwt_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  logic [cpwt_pkg::KIND_W-1:0]      s_tuser,
  input  logic                             q_full,
  output logic                             push,
  output cpwt_pkg::cmd_t                   push_cmd
);
  import cpwt_pkg::*;

  logic [ADDR_W-1:0]   address;
  logic [INSN_W-1:0]   insn_count;
  logic                thumb_mode;
  logic [WSIZE_W-1:0]  write_size;
  logic [REGION_W-1:0] region;
  logic                is_fast;
  logic                in_region;
  logic [END_W-1:0]    mask;
  logic [WSIZE_W-1:0]  mark_bytes;
  kind_t               kind;

  assign address    = s_tdata[ADDR_W-1:0];
  assign insn_count = s_tdata[ADDR_W+INSN_W-1:ADDR_W];
  assign thumb_mode = s_tdata[ADDR_W+INSN_W];
  assign write_size = s_tdata[ADDR_W+INSN_W+WSIZE_W:ADDR_W+INSN_W+1];
  assign kind       = kind_t'(s_tuser);

  assign region     = address[ADDR_W-1:REGION_SHIFT];
  assign is_fast    = (region == REGION_FAST);
  assign in_region  = is_fast || (region == REGION_WORK);
  assign mask       = is_fast ? FAST_MASK : WORK_MASK;
  assign mark_bytes = thumb_mode ? (WSIZE_W'(insn_count) << 1) : (WSIZE_W'(insn_count) << 2);

  always_comb begin
    push_cmd.fast  = is_fast;
    push_cmd.start = END_W'(address[OFF_W-1:0]) & mask;
    push_cmd.bytes = write_size;
    push_cmd.op    = OP_NONE;
    unique case (kind)
      KIND_MARK: begin
        push_cmd.bytes = mark_bytes;
        push_cmd.op    = (insn_count != '0 && in_region) ? OP_MARK : OP_NONE;
      end
      KIND_CHECK: begin
        push_cmd.op = (write_size != '0 && in_region) ? OP_CHECK : OP_NONE;
      end
      KIND_RESET: push_cmd.op = OP_RESET;
      KIND_TAKE:  push_cmd.op = OP_TAKE;
      default:    push_cmd.op = OP_NONE;
    endcase
  end

  assign s_tready = !q_full;
  assign push     = s_tvalid && !q_full;

endmodule

// ----- rtl/cpwt_queue.sv -----
// ----------------------------------------------------------------------------
// Tracker command queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module cpwt_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  cpwt_pkg::cmd_t push_cmd,
  output logic           full,
  output logic           valid,
  input  logic           pop,
  output cpwt_pkg::cmd_t pop_cmd
);
  import cpwt_pkg::*;

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign valid   = (count != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign pop_cmd = entries[rd_ptr];

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= ptr_inc(wr_ptr);
      if (do_pop)  rd_ptr <= ptr_inc(rd_ptr);
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_cmd;
  end

endmodule

// ----- rtl/cpwt_back.sv -----
// ----------------------------------------------------------------------------
// Tracker back end
// Walks the page range of each command over the bitmap memory and
// registers one result word per command.
// ----------------------------------------------------------------------------
module cpwt_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             q_valid,
  input  cpwt_pkg::cmd_t                   q_cmd,
  output logic                             q_pop,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [cpwt_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import cpwt_pkg::*;

  bk_state_t          state;
  bk_state_t          state_next;

  op_t                op;
  logic               fast;
  logic [END_W-1:0]   pos;
  logic [END_W-1:0]   cur;
  logic [END_W-1:0]   end_off;
  logic               final_step;
  logic [ROW_W-1:0]   rd_row;
  logic [BIT_W-1:0]   rd_bit;

  logic [ROW_BITS-1:0] mem [NUM_ROWS];
  logic [ROW_BITS-1:0] rdata;
  logic [NUM_ROWS-1:0] row_valid;

  logic               res_hit;
  logic               res_flushed;
  logic [COUNT_W-1:0] res_count;
  logic [COUNT_W-1:0] flush_count;
  logic               out_hit;
  logic               out_flushed;
  logic [COUNT_W-1:0] out_count;

  logic [END_W-1:0]    page_full;
  logic [END_W-1:0]    row_full;
  logic [ROW_W-1:0]    vis_row;
  logic [BIT_W-1:0]    vis_bit;
  logic [ROW_BITS-1:0] word;
  logic                bit_set;
  logic [END_W-1:0]    nxt;
  logic                more;

  logic mem_we;
  logic hit_now;
  logic clear_all;
  logic count_clear;
  logic count_inc;
  logic load_out;

  // Page and row of the offset being visited.
  assign page_full = (pos & (fast ? FAST_MASK : WORK_MASK)) >> PAGE_SHIFT;
  assign row_full  = (page_full >> BIT_W) + (fast ? '0 : WORK_BASE);
  assign vis_row   = row_full[ROW_W-1:0];
  assign vis_bit   = page_full[BIT_W-1:0];

  // A row that was never written since the last clear reads as zero.
  assign word    = row_valid[rd_row] ? rdata : '0;
  assign bit_set = word[rd_bit];
  assign nxt     = cur + PAGE_STEP;
  assign more    = (nxt < end_off);

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (q_valid) begin
          state_next = (q_cmd.op == OP_MARK || q_cmd.op == OP_CHECK) ? BK_READ : BK_DONE;
        end
      end
      BK_READ: state_next = BK_TEST;
      BK_TEST: begin
        if ((op == OP_CHECK && bit_set) || final_step) state_next = BK_DONE;
        else state_next = BK_READ;
      end
      BK_DONE: begin
        if (!m_tvalid || m_tready) state_next = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop       = 1'b0;
    mem_we      = 1'b0;
    hit_now     = 1'b0;
    count_clear = 1'b0;
    load_out    = 1'b0;
    unique case (state)
      BK_IDLE: begin
        q_pop       = q_valid;
        count_clear = q_valid && (q_cmd.op == OP_RESET || q_cmd.op == OP_TAKE);
      end
      BK_READ: ;
      BK_TEST: begin
        mem_we  = (op == OP_MARK);
        hit_now = (op == OP_CHECK) && bit_set;
      end
      BK_DONE: load_out = !m_tvalid || m_tready;
      default: ;
    endcase
    count_inc = hit_now;
    clear_all = hit_now || (q_pop && q_cmd.op == OP_RESET);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= BK_IDLE;
      row_valid   <= '0;
      flush_count <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      state <= state_next;
      if (clear_all) row_valid <= '0;
      else if (mem_we) row_valid[rd_row] <= 1'b1;
      if (count_clear) flush_count <= '0;
      else if (count_inc) flush_count <= flush_count + 1'b1;
      if (load_out) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      op          <= q_cmd.op;
      fast        <= q_cmd.fast;
      pos         <= q_cmd.start;
      cur         <= q_cmd.start;
      end_off     <= q_cmd.start + END_W'(q_cmd.bytes);
      final_step  <= 1'b0;
      res_hit     <= 1'b0;
      res_flushed <= (q_cmd.op == OP_RESET);
      res_count   <= (q_cmd.op == OP_TAKE) ? flush_count : '0;
    end
    if (state == BK_READ) begin
      rd_row <= vis_row;
      rd_bit <= vis_bit;
    end
    if (state == BK_TEST) begin
      if (hit_now) begin
        res_hit     <= 1'b1;
        res_flushed <= 1'b1;
      end else if (more && !final_step) begin
        cur <= nxt;
        pos <= nxt;
      end else begin
        // The walk ends on the page of the last byte.
        final_step <= 1'b1;
        pos        <= end_off - 1'b1;
      end
    end
    if (load_out) begin
      out_hit     <= res_hit;
      out_flushed <= res_flushed;
      out_count   <= res_count;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[rd_row] <= word | (ROW_BITS'(1) << rd_bit);
    rdata <= mem[vis_row];
  end

  assign m_tdata = {(OUT_TDATA_W - COUNT_W - 2)'(0), out_count, out_flushed, out_hit};

endmodule

// ----- rtl/code_page_write_tracker.sv -----
// ----------------------------------------------------------------------------
// Code page write tracker
// Keeps a code-present bit per page for fast RAM and work RAM, flushes both
// bitmaps when a write lands on a page with code, and counts those flushes.
// ----------------------------------------------------------------------------
//
// Channel  Dir  tdata fields (lowest bit first)                 tuser
// s_       in   address, insn_count, thumb_mode, write_size     kind
// m_       out  code_hit, flushed, invalidation_count           -
//
// A word shows up in the command queue on the cycle after it is accepted, and
// an idle back end takes it in that same cycle. The back end then visits each
// page in a read state and then a test state, and a done state loads the result
// into the output register. A mark or check visits ceil(bytes / page size) + 1
// pages, the last one being the page of the final byte; a check stops at its
// first hit. Reset, take, empty words and words that touch no region go from
// the idle state straight to the done state. The pace is set by the single
// read port of the bitmap memory, read on each visited page and written back
// for a mark. Reset (rst, synchronous) clears the per-row valid bits at once,
// so no clearing pass is needed. A stalled output holds the result register;
// the two-entry queue keeps accepting meanwhile until it is full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module code_page_write_tracker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // [31:0] address, [41:32] insn_count, [42] thumb_mode, [58:43] write_size
  input  logic [cpwt_pkg::IN_TDATA_W-1:0]  s_tdata,
  // [1:0] kind
  input  logic [cpwt_pkg::KIND_W-1:0]      s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [0] code_hit, [1] flushed, [33:2] invalidation_count
  output logic [cpwt_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import cpwt_pkg::*;

  // Commands travel from the front end through the queue to the back end.
  cmd_t push_cmd;
  cmd_t pop_cmd;
  logic push;
  logic q_full;
  logic q_valid;
  logic q_pop;

  cpwt_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  cpwt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .valid    (q_valid),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd)
  );

  cpwt_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_cmd    (pop_cmd),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // A hit always comes with a flush.
  `ASSERT_IMPLIES(a_hit_flushes, clk, rst, m_tvalid && m_tdata[0], m_tdata[1])

  // A nonzero count only comes from a take, which neither hits nor flushes.
  `ASSERT_IMPLIES(a_count_alone, clk, rst, m_tvalid && |m_tdata[33:2], !m_tdata[0] && !m_tdata[1])

  // An accepted word is waiting in the queue on the next cycle.
  `ASSERT_NEXT(a_accept_queued, clk, rst, s_tvalid && s_tready, q_valid)

endmodule
